// ===== rtl/snc_pkg.sv =====
// Shared types and constants for the sorting network checker.
`default_nettype none
package snc_pkg;

    localparam int WIRE_W  = 4;
    localparam int CFG_W   = 4;
    localparam int LVL_W   = 9;
    localparam int STORE_W = 2 * WIRE_W;

    localparam logic [LVL_W-1:0] LVL_MAX        = 9'd511;
    localparam logic [CFG_W-1:0] WIRE_COUNT_RST = 4'd12;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef struct packed {
        logic load;
        logic lvl_a;
        logic lvl_b;
        logic vec_init;
        logic run;
        logic eval;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic store_ok;
        logic err_set;
        logic drained;
        logic sorted;
        logic vec_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/snc_ctrl.sv =====
// Controller state machine: load sequencing and exhaustive check sequencing.
`default_nettype none
module snc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_last,
    input  wire snc_pkg::t_sts i_sts,
    output snc_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_result_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LVL_A,
        S_LVL_B,
        S_VEC,
        S_RUN,
        S_EVAL,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;
    logic   r_last;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    if (i_sts.store_ok) begin
                        n_state = S_LVL_A;
                    end else if (i_last) begin
                        n_state = S_VEC;
                    end
                end
            end
            S_LVL_A: begin
                o_cmd.lvl_a = 1'b1;
                n_state     = S_LVL_B;
            end
            S_LVL_B: begin
                o_cmd.lvl_b = 1'b1;
                n_state     = r_last ? S_VEC : S_IDLE;
            end
            S_VEC: begin
                o_cmd.vec_init = 1'b1;
                n_state        = i_sts.err_set ? S_RESULT : S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                if (i_sts.drained) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.sorted || i_sts.vec_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_VEC;
                end
            end
            S_RESULT: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_RESULT);
            if (accept) begin
                r_last <= i_last;
            end
        end
    end

    assign o_busy         = r_busy;
    assign o_result_valid = r_valid;

endmodule
`default_nettype wire

// ===== rtl/snc_dp.sv =====
// Datapath: comparator store, wire levels, depth, error and zero-one vector engine.
`default_nettype none
module snc_dp #(
    parameter int MAX_WIRES       = 12,
    parameter int MAX_COMPARATORS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [snc_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_has_pair,
    input  wire logic [snc_pkg::WIRE_W-1:0]  i_wire_a,
    input  wire logic [snc_pkg::WIRE_W-1:0]  i_wire_b,
    input  wire snc_pkg::t_cmd               i_cmd,
    output snc_pkg::t_sts                    o_sts,
    output logic                             o_is_sorting,
    output logic [snc_pkg::LVL_W-1:0]        o_depth,
    output logic [1:0]                       o_error
);

    localparam int CW = $clog2(MAX_COMPARATORS + 1);
    localparam int AW = (MAX_COMPARATORS > 1) ? $clog2(MAX_COMPARATORS) : 1;
    localparam int WW = $clog2(MAX_WIRES);
    localparam int LW = snc_pkg::LVL_W;
    localparam int IW = snc_pkg::WIRE_W;

    // configuration and control state
    logic [snc_pkg::CFG_W-1:0] r_wire_count;
    logic [CW-1:0]             r_cnt;
    logic [LW-1:0]             r_depth;
    snc_pkg::t_err             r_err;
    snc_pkg::t_err             n_err;
    logic                      r_fail;
    logic [MAX_WIRES-1:0]      r_vec;
    logic [CW-1:0]             r_idx;
    logic                      r_rdv;
    logic [MAX_WIRES-1:0]      r_lvl_vld;

    // payload
    logic [snc_pkg::STORE_W-1:0] store_mem [MAX_COMPARATORS];
    logic [snc_pkg::STORE_W-1:0] r_rd_data;
    logic [LW-1:0]               lvl_mem [MAX_WIRES];
    logic [LW-1:0]               r_lvl_a;
    logic [LW-1:0]               r_lvl_b;
    logic                        r_va;
    logic                        r_vb;
    logic [LW-1:0]               r_lvl_new;
    logic [IW-1:0]               r_wa;
    logic [IW-1:0]               r_wb;
    logic [MAX_WIRES-1:0]        r_work;

    // combinational
    logic [IW-1:0]          n_eff;
    logic                   in_range;
    logic                   full;
    logic                   store_we;
    logic [LW-1:0]          eff_a;
    logic [LW-1:0]          eff_b;
    logic [LW-1:0]          lvl_max;
    logic [LW-1:0]          n_lvl;
    logic [MAX_WIRES-1:0]   v_last;
    logic [MAX_WIRES-1:0]   inner;
    logic [IW-1:0]          rd_a;
    logic [IW-1:0]          rd_b;
    logic [MAX_WIRES-1:0]   one;
    logic [MAX_WIRES-1:0]   n_work;

    assign n_eff = (32'(r_wire_count) > MAX_WIRES) ? IW'(MAX_WIRES) : r_wire_count;

    assign in_range = (i_wire_a < n_eff) && (i_wire_b < n_eff);
    assign full     = (r_cnt >= CW'(MAX_COMPARATORS));
    assign store_we = i_cmd.load && i_has_pair && in_range && !full;

    always_comb begin
        n_err = r_err;
        if (i_cmd.clear) begin
            n_err = snc_pkg::ERR_NONE;
        end else if (r_err == snc_pkg::ERR_NONE && i_cmd.load && i_has_pair) begin
            if (!in_range) begin
                n_err = snc_pkg::ERR_RANGE;
            end else if (full) begin
                n_err = snc_pkg::ERR_FULL;
            end
        end
    end

    assign eff_a   = r_va ? r_lvl_a : '0;
    assign eff_b   = r_vb ? r_lvl_b : '0;
    assign lvl_max = (eff_a > eff_b) ? eff_a : eff_b;
    assign n_lvl   = (lvl_max == snc_pkg::LVL_MAX) ? lvl_max : lvl_max + 1'b1;

    always_comb begin
        for (int j = 0; j < MAX_WIRES; j++) begin
            v_last[j] = (32'(n_eff) > j);
        end
    end
    assign inner = v_last >> 1;

    // one comparator applied to the working vector
    assign rd_a = r_rd_data[snc_pkg::STORE_W-1:IW];
    assign rd_b = r_rd_data[IW-1:0];
    assign one  = MAX_WIRES'(1);
    always_comb begin
        n_work = r_work;
        if (rd_a < n_eff && rd_b < n_eff && ((r_work >> rd_a) & one) == one
                && ((r_work >> rd_b) & one) == '0) begin
            n_work = (r_work & ~(one << rd_a)) | (one << rd_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_count <= snc_pkg::WIRE_COUNT_RST;
            r_cnt        <= '0;
            r_depth      <= '0;
            r_err        <= snc_pkg::ERR_NONE;
            r_fail       <= 1'b0;
            r_vec        <= '0;
            r_idx        <= '0;
            r_rdv        <= 1'b0;
            r_lvl_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wire_count <= i_cfg_wdata;
            end
            r_err <= n_err;
            if (store_we) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.lvl_a) begin
                r_lvl_vld[r_wa[WW-1:0]] <= 1'b1;
                if (n_lvl > r_depth) begin
                    r_depth <= n_lvl;
                end
            end
            if (i_cmd.lvl_b) begin
                r_lvl_vld[r_wb[WW-1:0]] <= 1'b1;
            end
            if (i_cmd.vec_init) begin
                r_idx <= '0;
                r_rdv <= 1'b0;
            end
            if (i_cmd.run) begin
                if (r_idx < r_cnt) begin
                    r_idx <= r_idx + 1'b1;
                    r_rdv <= 1'b1;
                end else begin
                    r_rdv <= 1'b0;
                end
            end
            if (i_cmd.eval) begin
                if (!o_sts.sorted) begin
                    r_fail <= 1'b1;
                end else if (!o_sts.vec_last) begin
                    r_vec <= r_vec + 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_cnt     <= '0;
                r_depth   <= '0;
                r_fail    <= 1'b0;
                r_vec     <= '0;
                r_lvl_vld <= '0;
            end
        end
    end

    // comparator store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[r_cnt[AW-1:0]] <= {i_wire_a, i_wire_b};
        end
        r_rd_data <= store_mem[r_idx[AW-1:0]];
    end

    // wire level store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lvl_a <= lvl_mem[i_wire_a[WW-1:0]];
            r_lvl_b <= lvl_mem[i_wire_b[WW-1:0]];
        end
        if (i_cmd.lvl_a) begin
            lvl_mem[r_wa[WW-1:0]] <= n_lvl;
        end else if (i_cmd.lvl_b) begin
            lvl_mem[r_wb[WW-1:0]] <= r_lvl_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wa <= i_wire_a;
            r_wb <= i_wire_b;
            r_va <= r_lvl_vld[i_wire_a[WW-1:0]];
            r_vb <= r_lvl_vld[i_wire_b[WW-1:0]];
        end
        if (i_cmd.lvl_a) begin
            r_lvl_new <= n_lvl;
        end
        if (i_cmd.vec_init) begin
            r_work <= r_vec;
        end else if (i_cmd.run && r_rdv) begin
            r_work <= n_work;
        end
    end

    assign o_sts.store_ok = i_has_pair && in_range && !full;
    assign o_sts.err_set  = (r_err != snc_pkg::ERR_NONE);
    assign o_sts.drained  = (r_idx == r_cnt) && !r_rdv;
    assign o_sts.sorted   = ((r_work & ~(r_work >> 1) & inner) == '0);
    assign o_sts.vec_last = (r_vec == v_last);

    assign o_is_sorting = !r_fail && (r_err == snc_pkg::ERR_NONE);
    assign o_depth      = r_depth;
    assign o_error      = r_err;

endmodule
`default_nettype wire

// ===== rtl/sorting_network_checker_unit.sv =====
// Top level of the sorting network checker.
//
// Usage: set the wire count through i_cfg_we / i_cfg_wdata while the block is
// idle (reset value 12, values above MAX_WIRES act as MAX_WIRES). Then send one
// comparator per transaction: a transaction is taken on a clock edge with start
// high and busy low. An item without a stored comparator and without i_last
// leaves busy low; an item whose comparator is stored holds busy while the two
// wire levels are written back one per cycle into the level store.
// The item with i_last set closes the network and starts the check: every
// zero-one vector of n wires is pushed through the k stored comparators, one
// comparator per cycle from the comparator memory, stopping at the first
// vector that does not come out sorted. A pending error skips the check.
// The result shows for one cycle with o_result_valid; the receiver cannot
// stall it. Afterwards count, levels, depth and error are cleared; the wire
// count keeps its value.
// Reset (synchronous, active low) empties the network and sets the wire count
// to 12; no clearing pass is needed.
`default_nettype none
module sorting_network_checker_unit #(
    parameter int MAX_WIRES       = 12,
    parameter int MAX_COMPARATORS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [snc_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_has_pair,
    input  wire logic [snc_pkg::WIRE_W-1:0]  i_wire_a,
    input  wire logic [snc_pkg::WIRE_W-1:0]  i_wire_b,
    input  wire logic                        i_last,
    output logic                             o_result_valid,
    output logic                             o_is_sorting,
    output logic [snc_pkg::LVL_W-1:0]        o_depth,
    output logic [1:0]                       o_error
);

    snc_pkg::t_cmd cmd;
    snc_pkg::t_sts sts;

    snc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_last         (i_last),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    snc_dp #(
        .MAX_WIRES       (MAX_WIRES),
        .MAX_COMPARATORS (MAX_COMPARATORS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_has_pair   (i_has_pair),
        .i_wire_a     (i_wire_a),
        .i_wire_b     (i_wire_b),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_is_sorting (o_is_sorting),
        .o_depth      (o_depth),
        .o_error      (o_error)
    );

endmodule
`default_nettype wire

// ===== rtl/snc_checker.sv =====
// Port-level assertions for the sorting network checker, bound to the top level.
`default_nettype none
module snc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_last,
    input wire logic       o_result_valid,
    input wire logic       o_is_sorting,
    input wire logic [1:0] o_error
);

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result shown while not busy");

    a_error_not_sorting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_error != 2'd0) |-> !o_is_sorting)
        else $error("sorting reported with an error");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_error != 2'd3))
        else $error("undefined error code");

    // a non-final transaction never produces a result on the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_result_valid)
        else $error("result after a non-final transaction");

endmodule

bind sorting_network_checker_unit snc_checker u_snc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last         (i_last),
    .o_result_valid (o_result_valid),
    .o_is_sorting   (o_is_sorting),
    .o_error        (o_error)
);
`default_nettype wire
